@@ design/assert_macros.svh @@
// Assertion helpers for the drive command block.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check under reset: skip while rst_n is low.
`define DDC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check at every edge, reset included.
`define DDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DDC_ASSERT(lbl, clk, rstn, prop, msg)
`define DDC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ design/ddc_pkg.sv @@
package ddc_pkg;

  localparam int SPEED_W   = 8;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CMD_RAW   = 2'd0,
    CMD_STEER = 2'd1,
    CMD_ACCEL = 2'd2,
    CMD_BRAKE = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN  = 2'd2;

  localparam logic [CFG_W-1:0] BASE_OFFSET_RST = 7'd10;
  localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = 7'd127;
  localparam logic [CFG_W-1:0] STEER_GAIN_RST  = 7'd10;

  // Brake level that asks for the reverse pulse
  localparam logic [7:0] BRAKE_PULSE_LEVEL = 8'd1;

  typedef logic signed [SPEED_W-1:0] speed_t;

  typedef struct packed {
    cmd_t        command;
    speed_t      raw_left;
    speed_t      raw_right;
    speed_t      direction;
    speed_t      amount;
    logic [7:0]  brake_level;
  } in_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] base_offset;
    logic [CFG_W-1:0] speed_limit;
    logic [CFG_W-1:0] steer_gain;
  } cfg_t;

  typedef struct packed {
    logic        left_forward;
    logic [7:0]  left_drive;
    logic        right_forward;
    logic [7:0]  right_drive;
    speed_t      left_now;
    speed_t      right_now;
    logic        last;
  } res_t;

endpackage

@@ design/ddc_in_if.sv @@
interface ddc_in_if;
  import ddc_pkg::*;

  logic       valid;
  logic       ready;
  cmd_t       command;
  speed_t     raw_left;
  speed_t     raw_right;
  speed_t     direction;
  speed_t     amount;
  logic [7:0] brake_level;

  modport source (output valid, command, raw_left, raw_right, direction, amount,
                  brake_level, input ready);
  modport sink (input valid, command, raw_left, raw_right, direction, amount,
                brake_level, output ready);
endinterface

@@ design/ddc_out_if.sv @@
interface ddc_out_if;
  import ddc_pkg::*;

  logic       valid;
  logic       ready;
  logic       left_forward;
  logic [7:0] left_drive;
  logic       right_forward;
  logic [7:0] right_drive;
  speed_t     left_now;
  speed_t     right_now;
  logic       last;

  modport source (output valid, left_forward, left_drive, right_forward, right_drive,
                  left_now, right_now, last, input ready);
  modport sink (input valid, left_forward, left_drive, right_forward, right_drive,
                left_now, right_now, last, output ready);
endinterface

@@ design/ddc_cfg_if.sv @@
interface ddc_cfg_if;
  import ddc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/ddc_calc.sv @@
module ddc_calc (
  input  ddc_pkg::in_item_t item,
  input  ddc_pkg::speed_t   left,
  input  ddc_pkg::speed_t   right,
  input  ddc_pkg::cfg_t     cfg,
  output ddc_pkg::res_t     res,
  output logic              pulse
);
  import ddc_pkg::*;

  typedef logic signed [15:0] wide_t;

  function automatic wide_t min_w(input wide_t a, input wide_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic wide_t max_w(input wide_t a, input wide_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic speed_t sat8(input wide_t v);
    if (v > 16'sd127) return 8'sd127;
    if (v < -16'sd128) return -8'sd128;
    return speed_t'(v[7:0]);
  endfunction

  // Magnitude plus offset, wrapped to 8 bits; zero speed drives nothing
  function automatic logic [7:0] drive_of(input speed_t s, input logic [CFG_W-1:0] ofs);
    logic [8:0] sx;
    logic [8:0] mag;
    logic [8:0] sum;
    sx  = {s[7], s};
    mag = s[7] ? (~sx + 9'd1) : sx;
    sum = mag + {2'b00, ofs};
    return (s == 8'sd0) ? 8'd0 : sum[7:0];
  endfunction

  wide_t       l_w, r_w, lim_w, dir_w, amt_w;
  logic [7:0]  dir_mag;
  logic [14:0] prod;
  wide_t       prod_w, room, shift, sum_lr, avg, step;
  wide_t       nl, nr;
  speed_t      sl, sr;

  assign l_w   = wide_t'(left);
  assign r_w   = wide_t'(right);
  assign lim_w = wide_t'({9'd0, cfg.speed_limit});
  assign dir_w = wide_t'(item.direction);
  assign amt_w = wide_t'(item.amount);

  assign dir_mag = item.direction[7] ? (~item.direction + 8'd1) : item.direction;
  assign prod    = {8'd0, cfg.steer_gain} * {7'd0, dir_mag};
  assign prod_w  = wide_t'({1'b0, prod});

  assign pulse = (item.command == CMD_BRAKE) && (item.brake_level == BRAKE_PULSE_LEVEL);

  always_comb begin
    room   = 16'sd0;
    shift  = 16'sd0;
    step   = 16'sd0;
    sum_lr = l_w + r_w;
    avg    = (sum_lr + (sum_lr[15] ? 16'sd1 : 16'sd0)) >>> 1;
    nl     = 16'sd0;
    nr     = 16'sd0;
    case (item.command)
      CMD_RAW: begin
        nl = wide_t'(item.raw_left);
        nr = wide_t'(item.raw_right);
      end
      CMD_STEER: begin
        if (dir_w < 16'sd0) begin
          room  = min_w(l_w + lim_w, lim_w - r_w);
          shift = min_w(prod_w, room);
          nl    = l_w - shift;
          nr    = r_w + shift;
        end else if (dir_w > 16'sd0) begin
          room  = min_w(lim_w - l_w, r_w + lim_w);
          shift = min_w(prod_w, room);
          nl    = l_w + shift;
          nr    = r_w - shift;
        end else begin
          nl = avg;
          nr = avg;
        end
      end
      CMD_ACCEL: begin
        if (amt_w > 16'sd0) begin
          step = min_w(amt_w, lim_w - max_w(l_w, r_w));
        end else begin
          step = max_w(amt_w, -lim_w - min_w(l_w, r_w));
        end
        nl = l_w + step;
        nr = r_w + step;
      end
      CMD_BRAKE: begin
        if (pulse) begin
          nl = (l_w > 16'sd0) ? -16'sd127 : 16'sd127;
          nr = (r_w > 16'sd0) ? -16'sd127 : 16'sd127;
        end
      end
      default: begin
        nl = 16'sd0;
        nr = 16'sd0;
      end
    endcase
  end

  assign sl = sat8(nl);
  assign sr = sat8(nr);

  always_comb begin
    res.left_forward  = (sl > 8'sd0);
    res.left_drive    = drive_of(sl, cfg.base_offset);
    res.right_forward = (sr > 8'sd0);
    res.right_drive   = drive_of(sr, cfg.base_offset);
    res.left_now      = sl;
    res.right_now     = sr;
    res.last          = !pulse;
  end
endmodule

@@ design/differential_drive_command_unit.sv @@
// An input transfer reaches its first result through the input register, then the result register.
// Throughput: one command per cycle while the result side accepts; a level-one brake gives two
//   results, the reverse pulse and then the stop, and the next command waits until the stop loads.
// Reset (rst_n low, synchronous): both wheel speeds to zero, base_offset 10, speed_limit 127,
//   steer_gain 10, both channel stages emptied.
`include "assert_macros.svh"

module differential_drive_command_unit (
  input logic      clk,
  input logic      rst_n,
  ddc_in_if.sink   in_ch,
  ddc_out_if.source out_ch,
  ddc_cfg_if.sink  cfg_ch
);
  import ddc_pkg::*;

  // Configuration registers
  cfg_t     cfg_r;

  // Wheel speed state: always matches the speeds of the newest result loaded
  speed_t   left_speed_r, left_speed_nxt;
  speed_t   right_speed_r, right_speed_nxt;

  // Input stage
  logic     in_valid_r, in_valid_nxt;
  in_item_t in_r;
  in_item_t in_item;

  // Result stage
  logic     out_valid_r, out_valid_nxt;
  res_t     out_r, out_nxt;

  // Stop result owed after a reverse pulse
  logic     pend_r, pend_nxt;

  res_t     calc_res;
  logic     calc_pulse;
  res_t     stop_res;

  logic     in_xfer;
  logic     out_xfer;
  logic     out_free;
  logic     load_item;
  logic     load_stop;

  // ------------------------------------------------------------------
  // Configuration: always ready, writes beyond the register list drop
  // ------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_offset <= BASE_OFFSET_RST;
      cfg_r.speed_limit <= SPEED_LIMIT_RST;
      cfg_r.steer_gain  <= STEER_GAIN_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_BASE_OFFSET: cfg_r.base_offset <= cfg_ch.data;
        CFG_SPEED_LIMIT: cfg_r.speed_limit <= cfg_ch.data;
        CFG_STEER_GAIN:  cfg_r.steer_gain  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Handshake control
  // ------------------------------------------------------------------
  // The result register frees when empty or when its transfer completes.
  assign out_free  = !out_valid_r || out_ch.ready;
  // The owed stop goes first; the next command waits in the input register.
  assign load_stop = pend_r && out_free;
  assign load_item = in_valid_r && !pend_r && out_free;

  // Take a new command whenever the input register is empty or drains this cycle.
  assign in_ch.ready = !in_valid_r || load_item;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;

  always_comb begin
    in_item.command     = in_ch.command;
    in_item.raw_left    = in_ch.raw_left;
    in_item.raw_right   = in_ch.raw_right;
    in_item.direction   = in_ch.direction;
    in_item.amount      = in_ch.amount;
    in_item.brake_level = in_ch.brake_level;
  end

  // ------------------------------------------------------------------
  // Speed update for the held command
  // ------------------------------------------------------------------
  ddc_calc u_calc (
    .item  (in_r),
    .left  (left_speed_r),
    .right (right_speed_r),
    .cfg   (cfg_r),
    .res   (calc_res),
    .pulse (calc_pulse)
  );

  // Stop after the pulse: both wheels at rest, nothing driven
  always_comb begin
    stop_res.left_forward  = 1'b0;
    stop_res.left_drive    = 8'd0;
    stop_res.right_forward = 1'b0;
    stop_res.right_drive   = 8'd0;
    stop_res.left_now      = 8'sd0;
    stop_res.right_now     = 8'sd0;
    stop_res.last          = 1'b1;
  end

  always_comb begin
    in_valid_nxt    = in_valid_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_nxt         = out_r;
    pend_nxt        = pend_r;
    left_speed_nxt  = left_speed_r;
    right_speed_nxt = right_speed_r;

    // Advance the input stage: fill on transfer, drop once consumed
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (load_item) begin
      in_valid_nxt = 1'b0;
    end

    if (load_stop) begin
      out_nxt         = stop_res;
      out_valid_nxt   = 1'b1;
      pend_nxt        = 1'b0;
      left_speed_nxt  = 8'sd0;
      right_speed_nxt = 8'sd0;
    end else if (load_item) begin
      out_nxt         = calc_res;
      out_valid_nxt   = 1'b1;
      pend_nxt        = calc_pulse;
      left_speed_nxt  = calc_res.left_now;
      right_speed_nxt = calc_res.right_now;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      pend_r        <= 1'b0;
      left_speed_r  <= 8'sd0;
      right_speed_r <= 8'sd0;
    end else begin
      in_valid_r    <= in_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      pend_r        <= pend_nxt;
      left_speed_r  <= left_speed_nxt;
      right_speed_r <= right_speed_nxt;
    end
  end

  // Payload registers: hold unless loaded
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_item;
    end
    out_r <= out_nxt;
  end

  // ------------------------------------------------------------------
  // Result channel
  // ------------------------------------------------------------------
  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_forward  = out_r.left_forward;
  assign out_ch.left_drive    = out_r.left_drive;
  assign out_ch.right_forward = out_r.right_forward;
  assign out_ch.right_drive   = out_r.right_drive;
  assign out_ch.left_now      = out_r.left_now;
  assign out_ch.right_now     = out_r.right_now;
  assign out_ch.last          = out_r.last;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `DDC_ASSERT(a_pend_needs_out, clk, rst_n, pend_r |-> out_valid_r, "stop owed with empty result register")
  `DDC_ASSERT(a_pulse_sets_pend, clk, rst_n, (out_valid_r && !out_r.last) |-> pend_r, "pulse result without owed stop")
  `DDC_ASSERT(a_stop_follows_pulse, clk, rst_n, (out_xfer && !out_r.last) |=> (out_valid_r && out_r.last && out_r.left_now == 8'sd0 && out_r.right_now == 8'sd0), "pulse not followed by stop")
  `DDC_ASSERT(a_state_matches_out, clk, rst_n, out_valid_r |-> (left_speed_r == out_r.left_now && right_speed_r == out_r.right_now), "speed state differs from shown result")
  `DDC_ASSERT(a_in_holds, clk, rst_n, (in_valid_r && !load_item) |=> (in_valid_r && $stable(in_r)), "held command lost")
endmodule

@@ verif/tb_differential_drive_command_unit.sv @@
`timescale 1ns / 100ps

module tb_differential_drive_command_unit;
  import ddc_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 300000;
  // Margin for a command to pass the input and result registers, plus the stop after a pulse brake
  localparam int SETTLE_CYCLES = 6;

  // Predictor of the drive command block plus the store of pending drive results
  class drive_command_scoreboard;
    int   left_spd;
    int   right_spd;
    int   base_offset;
    int   speed_limit;
    int   steer_gain;
    res_t pending_drive[$];
    int   errors;

    function new();
      left_spd    = 0;
      right_spd   = 0;
      base_offset = int'(BASE_OFFSET_RST);
      speed_limit = int'(SPEED_LIMIT_RST);
      steer_gain  = int'(STEER_GAIN_RST);
      errors      = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_BASE_OFFSET: base_offset = int'(data);
        CFG_SPEED_LIMIT: speed_limit = int'(data);
        CFG_STEER_GAIN:  steer_gain  = int'(data);
        default: ;
      endcase
    endfunction

    function int clamp8(int v);
      if (v > 127) return 127;
      if (v < -128) return -128;
      return v;
    endfunction

    function logic [7:0] drive_level(int s);
      int mag;
      if (s == 0) return 8'd0;
      mag = (s < 0) ? -s : s;
      return 8'(mag + base_offset);
    endfunction

    // Move the wheels to the new speeds and queue the bridge command they give
    function void push_drive(int l, int r, bit fin);
      res_t d;
      left_spd        = clamp8(l);
      right_spd       = clamp8(r);
      d.left_forward  = (left_spd > 0);
      d.left_drive    = drive_level(left_spd);
      d.right_forward = (right_spd > 0);
      d.right_drive   = drive_level(right_spd);
      d.left_now      = speed_t'(left_spd);
      d.right_now     = speed_t'(right_spd);
      d.last          = fin;
      pending_drive.push_back(d);
    endfunction

    function int min2(int a, int b);
      return (a < b) ? a : b;
    endfunction

    function int max2(int a, int b);
      return (a > b) ? a : b;
    endfunction

    function void note_command(in_item_t it);
      int l   = left_spd;
      int r   = right_spd;
      int lim = speed_limit;
      int dir = it.direction;
      int amt = it.amount;
      int room;
      int shift;
      int stp;
      case (it.command)
        CMD_RAW: push_drive(it.raw_left, it.raw_right, 1'b1);
        CMD_STEER: begin
          if (dir < 0) begin
            room  = min2(l + lim, lim - r);
            shift = min2(steer_gain * -dir, room);
            push_drive(l - shift, r + shift, 1'b1);
          end else if (dir > 0) begin
            room  = min2(lim - l, r + lim);
            shift = min2(steer_gain * dir, room);
            push_drive(l + shift, r - shift, 1'b1);
          end else begin
            push_drive((l + r) / 2, (l + r) / 2, 1'b1);
          end
        end
        CMD_ACCEL: begin
          if (amt > 0) stp = min2(amt, lim - max2(l, r));
          else stp = max2(amt, -lim - min2(l, r));
          push_drive(l + stp, r + stp, 1'b1);
        end
        default: begin
          if (it.brake_level == BRAKE_PULSE_LEVEL) begin
            push_drive((l > 0) ? -127 : 127, (r > 0) ? -127 : 127, 1'b0);
          end
          push_drive(0, 0, 1'b1);
        end
      endcase
    endfunction

    function void field_check(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_d;
      if (pending_drive.size() == 0) begin
        $display("%0t ns: drive result with nothing pending, got %p", $time, got);
        errors++;
        return;
      end
      exp_d = pending_drive.pop_front();
      field_check("left_forward", exp_d.left_forward, got.left_forward);
      field_check("left_drive", exp_d.left_drive, got.left_drive);
      field_check("right_forward", exp_d.right_forward, got.right_forward);
      field_check("right_drive", exp_d.right_drive, got.right_drive);
      field_check("left_now", exp_d.left_now, got.left_now);
      field_check("right_now", exp_d.right_now, got.right_now);
      field_check("last", exp_d.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  bit   idle_on;     // random gaps on the command side
  bit   stalls_on;   // random back-pressure on the result side
  int   stall_left;

  drive_command_scoreboard sb;

  ddc_in_if  in_ch();
  ddc_out_if out_ch();
  ddc_cfg_if cfg_ch();

  differential_drive_command_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Hard stop in case the block hangs or loses a result
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sample all three channels at the rising edge; inputs only move on the falling edge
  always @(posedge clk) begin
    in_item_t acc;
    res_t     got;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.set_register(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        acc.command     = in_ch.command;
        acc.raw_left    = in_ch.raw_left;
        acc.raw_right   = in_ch.raw_right;
        acc.direction   = in_ch.direction;
        acc.amount      = in_ch.amount;
        acc.brake_level = in_ch.brake_level;
        sb.note_command(acc);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.left_forward  = out_ch.left_forward;
        got.left_drive    = out_ch.left_drive;
        got.right_forward = out_ch.right_forward;
        got.right_drive   = out_ch.right_drive;
        got.left_now      = out_ch.left_now;
        got.right_now     = out_ch.right_now;
        got.last          = out_ch.last;
        sb.check_result(got);
      end
    end
  end

  // Result-side back-pressure: stall bursts of random length, long open stretches between
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (stalls_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
      end
    end
  end

  function automatic in_item_t make_command(cmd_t c, int rl, int rr, int dir, int amt,
                                            int lvl);
    in_item_t it;
    it.command     = c;
    it.raw_left    = speed_t'(rl);
    it.raw_right   = speed_t'(rr);
    it.direction   = speed_t'(dir);
    it.amount      = speed_t'(amt);
    it.brake_level = 8'(lvl);
    return it;
  endfunction

  function automatic in_item_t random_command();
    in_item_t it;
    it.command     = cmd_t'($urandom_range(0, 3));
    it.raw_left    = speed_t'($urandom);
    it.raw_right   = speed_t'($urandom);
    it.direction   = speed_t'($urandom);
    it.amount      = speed_t'($urandom);
    // favor the reverse-pulse brake, otherwise any level
    it.brake_level = ($urandom_range(0, 2) == 0) ? BRAKE_PULSE_LEVEL : 8'($urandom);
    return it;
  endfunction

  // Hold valid low for the gap, then present the command until the transfer happens
  task automatic send_command(in_item_t it);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) < 12) ? $urandom_range(1, 19) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.command     = it.command;
    in_ch.raw_left    = it.raw_left;
    in_ch.raw_right   = it.raw_right;
    in_ch.direction   = it.direction;
    in_ch.amount      = it.amount;
    in_ch.brake_level = it.brake_level;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every pending drive result has come back
  task automatic drain_commands();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = CFG_W'(data);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic load_config(int base, int limit, int gain);
    drain_commands();
    write_register(CFG_BASE_OFFSET, base);
    write_register(CFG_SPEED_LIMIT, limit);
    write_register(CFG_STEER_GAIN, gain);
  endtask

  task automatic run_random(int count);
    repeat (count) send_command(random_command());
  endtask

  initial begin
    in_item_t directed[$];

    sb          = new();
    cycle_count = 0;
    idle_on     = 1'b0;
    stalls_on   = 1'b0;
    stall_left  = 0;

    // Known values on every input from time zero
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_RAW;
    in_ch.raw_left    = '0;
    in_ch.raw_right   = '0;
    in_ch.direction   = '0;
    in_ch.amount      = '0;
    in_ch.brake_level = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_BASE_OFFSET;
    cfg_ch.data       = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pass under reset settings: field extremes, every command,
    // averaging with truncation toward zero, saturation, and each brake form
    directed.push_back(make_command(CMD_RAW, 127, -128, 0, 0, 0));
    directed.push_back(make_command(CMD_RAW, -128, 127, 0, 0, 0));
    directed.push_back(make_command(CMD_RAW, 0, 0, 0, 0, 0));
    directed.push_back(make_command(CMD_RAW, 5, -2, 0, 0, 0));
    directed.push_back(make_command(CMD_STEER, 0, 0, 0, 0, 0));
    directed.push_back(make_command(CMD_RAW, -5, 2, 0, 0, 0));
    directed.push_back(make_command(CMD_STEER, 0, 0, 0, 0, 0));
    directed.push_back(make_command(CMD_RAW, -128, -128, 0, 0, 0));
    directed.push_back(make_command(CMD_STEER, 0, 0, 127, 0, 0));
    directed.push_back(make_command(CMD_STEER, 0, 0, -128, 0, 0));
    directed.push_back(make_command(CMD_STEER, 0, 0, 1, 0, 0));
    directed.push_back(make_command(CMD_STEER, 0, 0, -1, 0, 0));
    directed.push_back(make_command(CMD_ACCEL, 0, 0, 0, 127, 0));
    directed.push_back(make_command(CMD_ACCEL, 0, 0, 0, -128, 0));
    directed.push_back(make_command(CMD_ACCEL, 0, 0, 0, 0, 0));
    directed.push_back(make_command(CMD_ACCEL, 0, 0, 0, 1, 0));
    directed.push_back(make_command(CMD_ACCEL, 0, 0, 0, -1, 0));
    directed.push_back(make_command(CMD_RAW, 30, -40, 0, 0, 0));
    directed.push_back(make_command(CMD_BRAKE, 0, 0, 0, 0, 1));
    directed.push_back(make_command(CMD_BRAKE, 0, 0, 0, 0, 0));
    directed.push_back(make_command(CMD_RAW, -20, 0, 0, 0, 0));
    directed.push_back(make_command(CMD_BRAKE, 0, 0, 0, 0, 1));
    directed.push_back(make_command(CMD_BRAKE, 0, 0, 0, 0, 255));
    directed.push_back(make_command(CMD_RAW, 127, 127, 0, 0, 0));
    directed.push_back(make_command(CMD_ACCEL, 0, 0, 0, 127, 0));
    directed.push_back(make_command(CMD_BRAKE, 0, 0, 0, 0, 1));
    directed.push_back(make_command(CMD_BRAKE, 0, 0, 0, 0, 2));
    foreach (directed[i]) send_command(directed[i]);

    // Random traffic with gaps and stalls under the reset settings
    idle_on   = 1'b1;
    stalls_on = 1'b1;
    run_random(90);

    // Low settings: no offset, speed limit of 1, no steering gain
    load_config(0, 1, 0);
    run_random(100);

    // Highest settings; pause mid-phase until the pipe is empty, then go on
    load_config(127, 127, 127);
    run_random(50);
    drain_commands();
    run_random(50);

    // Zero speed limit passes straight through to the headroom math
    load_config(127, 0, 1);
    run_random(70);

    load_config(5, 20, 2);
    run_random(100);

    // Last stretch at full rate on both sides
    load_config($urandom_range(0, 127), $urandom_range(1, 127), $urandom_range(0, 127));
    idle_on   = 1'b0;
    stalls_on = 1'b0;
    run_random(90);

    drain_commands();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
